/* src/sll_pkg.sv */
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and helpers for the static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int POS_W   = 5;
  localparam int SLOT_W  = 5;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_FIND,
    OP_DELETE,
    OP_DUMP
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_BAD_POS,
    STAT_NOT_FOUND
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_FREE,
    S_INS_FNXT,
    S_INS_WALK,
    S_INS_FIN,
    S_FD_LINK,
    S_FD_CMP,
    S_DEL_RD,
    S_DEL_FIN,
    S_DP_LINK,
    S_DP_OUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [SLOT_W-1:0]         node_slot;
    logic signed [VALUE_W-1:0] node_value;
    logic                      last;
  } rsp_item_t;

  function automatic rsp_item_t make_rsp(status_t st, logic [SLOT_W-1:0] slot,
                                         logic signed [VALUE_W-1:0] value,
                                         logic is_last);
    rsp_item_t r;
    r.status     = st;
    r.node_slot  = slot;
    r.node_value = value;
    r.last       = is_last;
    return r;
  endfunction

endpackage

/* src/sll_ram.sv */
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sll_ctrl.sv */
// ----------------------------------------------------------------------------
// sll_ctrl
// Sequencer for the list engine: init sweep, link walks and write-backs.
// ----------------------------------------------------------------------------
module sll_ctrl #(
  parameter int NODES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  sll_pkg::req_item_t       req,
  output logic                     req_stall,
  output logic                     link_we,
  output logic [$clog2(NODES)-1:0] link_waddr,
  output logic [$clog2(NODES)-1:0] link_wdata,
  input  logic [$clog2(NODES)-1:0] link_rdata,
  output logic                     data_we,
  output logic [$clog2(NODES)-1:0] data_waddr,
  output logic [sll_pkg::VALUE_W-1:0] data_wdata,
  input  logic [sll_pkg::VALUE_W-1:0] data_rdata,
  output logic                     rd_en,
  output logic [$clog2(NODES)-1:0] rd_addr,
  output logic                     emit,
  output sll_pkg::rsp_item_t       emit_item,
  input  logic                     emit_ready
);
  import sll_pkg::*;

  localparam int IW    = $clog2(NODES);
  localparam int CMP_W = ((IW > POS_W) ? IW : POS_W) + 1;
  localparam logic [IW-1:0] HEAD = IW'(NODES - 1);
  localparam logic [IW-1:0] FREE = '0;

  state_t state, state_next;
  logic [IW-1:0]      cur, prev, fresh, count;
  logic [POS_W-1:0]   remain;
  logic [1:0]         op;
  logic [VALUE_W-1:0] val;
  rsp_item_t          res;

  logic at_end, hit, pos_bad;

  assign at_end  = (link_rdata == FREE) || (link_rdata == HEAD);
  assign hit     = (data_rdata == val);
  assign pos_bad = (req.position == '0) ||
                   (CMP_W'(req.position) > (CMP_W'(count) + CMP_W'(1)));

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (cur == HEAD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.operation)
            OP_INSERT: state_next = pos_bad ? S_EMIT : S_INS_FREE;
            OP_FIND,
            OP_DELETE: state_next = S_FD_LINK;
            OP_DUMP:   state_next = S_DP_LINK;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_INS_FREE: state_next = at_end ? S_EMIT : S_INS_FNXT;
      S_INS_FNXT: state_next = S_INS_WALK;
      S_INS_WALK: begin
        if (remain == '0) state_next = S_INS_FIN;
      end
      S_INS_FIN:  state_next = S_EMIT;
      S_FD_LINK:  state_next = at_end ? S_EMIT : S_FD_CMP;
      S_FD_CMP: begin
        if (hit) begin
          state_next = (op == OP_DELETE) ? S_DEL_RD : S_EMIT;
        end else if (at_end) begin
          state_next = S_EMIT;
        end
      end
      S_DEL_RD:   state_next = S_DEL_FIN;
      S_DEL_FIN:  state_next = S_EMIT;
      S_DP_LINK:  state_next = at_end ? S_EMIT : S_DP_OUT;
      S_DP_OUT: begin
        if (emit_ready && at_end) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (emit_ready) state_next = S_IDLE;
      end
      default:    state_next = S_INIT;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = '0;
    data_we    = 1'b0;
    data_waddr = fresh;
    data_wdata = val;
    rd_en      = 1'b0;
    rd_addr    = link_rdata;
    emit       = 1'b0;
    emit_item  = res;
    unique case (state)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = ({1'b0, cur} < (IW + 1)'(NODES - 2)) ? cur + IW'(1) : '0;
      end
      S_IDLE: begin
        req_stall = 1'b0;
        rd_en     = 1'b1;
        rd_addr   = (req.operation == OP_INSERT) ? FREE : HEAD;
      end
      S_INS_FREE: begin
        rd_en = 1'b1;
      end
      S_INS_FNXT: begin
        link_we    = 1'b1;
        link_waddr = FREE;
        link_wdata = link_rdata;
        data_we    = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = HEAD;
      end
      S_INS_WALK: begin
        if (remain == '0) begin
          link_we    = 1'b1;
          link_waddr = fresh;
          link_wdata = link_rdata;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_INS_FIN: begin
        link_we    = 1'b1;
        link_waddr = prev;
        link_wdata = fresh;
      end
      S_FD_LINK: begin
        rd_en = 1'b1;
      end
      S_FD_CMP: begin
        if (hit) begin
          if (op == OP_DELETE) begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = link_rdata;
            rd_en      = 1'b1;
            rd_addr    = FREE;
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      S_DEL_RD: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_rdata;
      end
      S_DEL_FIN: begin
        link_we    = 1'b1;
        link_waddr = FREE;
        link_wdata = cur;
      end
      S_DP_LINK: begin
        rd_en = 1'b1;
      end
      S_DP_OUT: begin
        emit      = 1'b1;
        emit_item = make_rsp(STAT_OK, SLOT_W'(cur), data_rdata, at_end);
        rd_en     = emit_ready && !at_end;
      end
      S_EMIT: begin
        emit = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cur   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT: cur <= cur + IW'(1);
        S_IDLE: begin
          if (req_valid) begin
            op     <= req.operation;
            val    <= req.item_value;
            remain <= req.position - POS_W'(1);
            prev   <= HEAD;
            res    <= make_rsp(STAT_BAD_POS, '0, '0, 1'b1);
          end
        end
        S_INS_FREE: begin
          fresh <= link_rdata;
          res   <= make_rsp(STAT_FULL, '0, '0, 1'b1);
        end
        S_INS_WALK: begin
          if (remain != '0) begin
            prev   <= link_rdata;
            remain <= remain - POS_W'(1);
          end
        end
        S_INS_FIN: begin
          count <= count + IW'(1);
          res   <= make_rsp(STAT_OK, SLOT_W'(fresh), val, 1'b1);
        end
        S_FD_LINK: begin
          cur <= link_rdata;
          res <= make_rsp(STAT_NOT_FOUND, '0, '0, 1'b1);
        end
        S_FD_CMP: begin
          if (hit) begin
            res <= make_rsp(STAT_OK, SLOT_W'(cur), val, 1'b1);
          end else begin
            prev <= cur;
            cur  <= link_rdata;
          end
        end
        S_DEL_FIN: count <= count - IW'(1);
        S_DP_LINK: begin
          cur <= link_rdata;
          res <= make_rsp(STAT_OK, '0, '0, 1'b1);
        end
        S_DP_OUT: begin
          if (emit_ready && !at_end) cur <= link_rdata;
        end
        default: begin
          cur <= cur;
        end
      endcase
    end
  end

endmodule

/* src/static_linked_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit
// Array-backed singly linked list with a free list, held in link/data RAMs.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, one link RAM read per list node walked; a dump
//   yields one item per cycle while the output is not stalled.
// Reset: synchronous; an init sweep then rebuilds the free chain in the link
//   RAM, with req_stall held high throughout.
module static_linked_list_engine_unit #(
  parameter int NODES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sll_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sll_pkg::rsp_item_t rsp
);
  import sll_pkg::*;

  localparam int IW = $clog2(NODES);

  // link RAM ports
  logic          link_we;
  logic [IW-1:0] link_waddr, link_wdata, link_rdata;
  // data RAM ports
  logic               data_we;
  logic [IW-1:0]      data_waddr;
  logic [VALUE_W-1:0] data_wdata, data_rdata;
  // shared read address: link and data of one node arrive together
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  logic      emit, emit_ready;
  rsp_item_t emit_item;

  // The sequencer never writes an entry in the cycle it reads the same one,
  // so the RAMs need no forwarding path.
  sll_ram #(.DEPTH(NODES), .WIDTH(IW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  sll_ram #(.DEPTH(NODES), .WIDTH(VALUE_W)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  sll_ctrl #(.NODES(NODES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_stall  (req_stall),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_rdata (link_rdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .data_rdata (data_rdata),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .emit       (emit),
    .emit_item  (emit_item),
    .emit_ready (emit_ready)
  );

  // Output register: load when empty or being drained this cycle, so the
  // sequencer can move on to the next item while a result waits downstream.
  assign emit_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_ready) begin
      rsp_valid <= emit;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (emit && emit_ready) begin
      rsp <= emit_item;
    end
  end

endmodule

/* src/sll_checker.sv */
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sll_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input sll_pkg::rsp_item_t rsp
);
  import sll_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result changed while stalled");

  // one item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken while first in flight");

  // every error status is a single, empty, final result
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |->
      (rsp.node_slot == '0) && (rsp.node_value == '0) && rsp.last)
    else $error("error result carries a node");

endmodule

bind static_linked_list_engine_unit sll_checker u_sll_checker (.*);
